@@ rtl/tpc_pkg.sv @@
`timescale 1ns / 1ps
package tpc_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int ADC_W       = 20;

  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_CALIB  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_LOW   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_HIGH  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_NINE  = 2'd3;

  localparam logic [63:0] FINE_OFFSET = 64'd128000;
  localparam logic [63:0] PRESS_BASE  = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE = 64'd3125;
  localparam logic [63:0] PRESS_BIAS  = 64'h0000_8000_0000_0000;
  localparam logic [31:0] TEMP_ROUND  = 32'd128;

  localparam logic CMD_TEMP  = 1'b0;
  localparam logic CMD_PRESS = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL,
    ST_T_X, ST_T_A, ST_T_S, ST_T_B, ST_T_OUT,
    ST_P_V1, ST_P_SQ, ST_P_V2A, ST_P_V2B, ST_P_N1, ST_P_N2, ST_P_N3, ST_P_F1,
    ST_P_CHK, ST_P_DIV0, ST_P_DIV, ST_P_Q1, ST_P_Q2, ST_P_Q3, ST_P_Q4,
    ST_P_SUM, ST_P_SUM2, ST_P_FIN, ST_FIN
  } state_t;

  typedef struct packed {
    logic       start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [63:0] quot;
  } div_rsp_t;

  function automatic logic [63:0] sext16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

@@ rtl/tpc_in_if.sv @@
`timescale 1ns / 1ps
interface tpc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [19:0] adc_value;
  modport source(output valid, command, adc_value, input ready);
  modport sink(input valid, command, adc_value, output ready);
endinterface

@@ rtl/tpc_out_if.sv @@
`timescale 1ns / 1ps
interface tpc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] temperature_centi;
  logic [31:0] pressure_q24_8;
  logic        zero_divisor;
  modport source(output valid, temperature_centi, pressure_q24_8, zero_divisor, input ready);
  modport sink(input valid, temperature_centi, pressure_q24_8, zero_divisor, output ready);
endinterface

@@ rtl/tpc_sdiv64.sv @@
`timescale 1ns / 1ps
module tpc_sdiv64 (
  input  logic              clk,
  input  logic              rst,
  input  tpc_pkg::div_req_t req,
  output tpc_pkg::div_rsp_t rsp
);
  import tpc_pkg::*;

  logic        running;
  logic        fix;
  logic [5:0]  cnt;
  logic        neg;
  logic [63:0] md;
  logic [63:0] rem;
  logic [63:0] dvd;
  logic [64:0] shifted;
  logic        fits;

  // one quotient bit per cycle, restoring
  assign shifted = {rem, dvd[63]};
  assign fits    = shifted >= {1'b0, md};

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      fix      <= 1'b0;
      rsp.done <= 1'b0;
      cnt      <= '0;
    end else begin
      rsp.done <= 1'b0;
      fix      <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= '0;
        neg     <= req.num[63] ^ req.den[63];
        dvd     <= req.num[63] ? (64'd0 - req.num) : req.num;
        md      <= req.den[63] ? (64'd0 - req.den) : req.den;
        rem     <= '0;
      end else if (running) begin
        rem <= fits ? (shifted[63:0] - md) : shifted[63:0];
        dvd <= {dvd[62:0], fits};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          running <= 1'b0;
          fix     <= 1'b1;
        end
      end else if (fix) begin
        rsp.quot <= neg ? (64'd0 - dvd) : dvd;
        rsp.done <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/temp_pressure_compensation_top.sv @@
`timescale 1ns / 1ps
// temperature and pressure compensation for a 20-bit barometric sensor
// in_ch carries a command (0 temperature, 1 pressure) and a raw adc value;
// out_ch returns one result per transfer: hundredths of a degree for a
// temperature command, Q24.8 pascals plus a zero-divisor flag for pressure
// calibration is written through write_enable / reg_index / write_data; the
// user must write it only while the block is idle, which is not enforced
// index 0 temp words, 1 and 2 pressure words, 3 P9; one item at a time:
// in_ch.ready is high only while the sequencer is idle
// all multiplication runs on one 32x32 multiplier; a 64-bit product is built
// from three partial products plus accumulate, and the separate signed divider
// runs one quotient bit per cycle, with operand setup and a final sign fix
// with a ready receiver the next item is taken the cycle after the result is
// loaded; a new item is accepted only once the last one is through
// a finished result sits in the output register until out_ch.ready; a
// stalled receiver holds the sequencer in its final state, nothing is lost
// reset clears calibration and the stored fine temperature to zero
module temp_pressure_compensation_top (
  input  logic                              clk,
  input  logic                              rst,
  tpc_in_if.sink                            in_ch,
  tpc_out_if.source                         out_ch,
  input  logic                              write_enable,
  input  logic [tpc_pkg::CFG_INDEX_W-1:0]   reg_index,
  input  logic [tpc_pkg::CFG_DATA_W-1:0]    write_data
);
  import tpc_pkg::*;

  // calibration registers
  logic [47:0] temp_calib;
  logic [63:0] press_calib_low;
  logic [63:0] press_calib_high;
  logic [15:0] press_calib_nine;
  logic [31:0] fine_temperature;

  state_t state, state_next, ret;

  // captured item
  logic [19:0] adc;

  // working registers
  logic [63:0] v1, v2, sq, acc, p;
  logic [31:0] ta;

  // shared multiplier
  logic [63:0] mul_a, mul_b, mul_r, prod;
  logic [1:0]  mul_phase;
  logic [31:0] op_a, op_b;

  // results
  logic [31:0] res_temp, res_press;
  logic        res_zero;
  logic        out_valid;

  // control from the output decode
  logic in_ready, load_out;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // calibration fields
  logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {48'd0, temp_calib[15:0]};
  assign t2 = sext16(temp_calib[31:16]);
  assign t3 = sext16(temp_calib[47:32]);
  assign p1 = {48'd0, press_calib_low[15:0]};
  assign p2 = sext16(press_calib_low[31:16]);
  assign p3 = sext16(press_calib_low[47:32]);
  assign p4 = sext16(press_calib_low[63:48]);
  assign p5 = sext16(press_calib_high[15:0]);
  assign p6 = sext16(press_calib_high[31:16]);
  assign p7 = sext16(press_calib_high[47:32]);
  assign p8 = sext16(press_calib_high[63:48]);
  assign p9 = sext16(press_calib_nine);

  // 32-bit temperature intermediates
  logic [31:0] tx, td, ts, tb, tfine, tscaled;
  assign tx      = {15'd0, adc[19:3]} - {15'd0, t1[15:0], 1'b0};
  assign td      = {16'd0, adc[19:4]} - {16'd0, t1[15:0]};
  assign ts      = 32'($signed(mul_r[31:0]) >>> 12);
  assign tb      = 32'($signed(mul_r[31:0]) >>> 14);
  assign tfine   = ta + tb;
  assign tscaled = {fine_temperature[29:0], 2'b00} + fine_temperature + TEMP_ROUND;

  // partial product select: low x low, high x low, low x high
  always_comb begin
    case (mul_phase)
      2'd0:    begin op_a = mul_a[31:0];  op_b = mul_b[31:0];  end
      2'd1:    begin op_a = mul_a[63:32]; op_b = mul_b[31:0];  end
      2'd2:    begin op_a = mul_a[31:0];  op_b = mul_b[63:32]; end
      default: begin op_a = mul_a[31:0];  op_b = mul_b[31:0];  end
    endcase
  end

  // output decode
  always_comb begin
    in_ready      = (state == ST_IDLE);
    load_out      = (state == ST_FIN) && (!out_valid || out_ch.ready);
    div_req.start = (state == ST_P_DIV0);
    div_req.num   = mul_r;
    div_req.den   = v1;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_ch.valid) state_next = (in_ch.command == CMD_PRESS) ? ST_P_V1 : ST_T_X;
      ST_MUL:    if (mul_phase == 2'd3) state_next = ret;
      ST_T_X:    state_next = ST_MUL;
      ST_T_A:    state_next = ST_MUL;
      ST_T_S:    state_next = ST_MUL;
      ST_T_B:    state_next = ST_T_OUT;
      ST_T_OUT:  state_next = ST_FIN;
      ST_P_V1:   state_next = ST_MUL;
      ST_P_SQ:   state_next = ST_MUL;
      ST_P_V2A:  state_next = ST_MUL;
      ST_P_V2B:  state_next = ST_MUL;
      ST_P_N1:   state_next = ST_MUL;
      ST_P_N2:   state_next = ST_P_N3;
      ST_P_N3:   state_next = ST_MUL;
      ST_P_F1:   state_next = ST_P_CHK;
      ST_P_CHK:  state_next = (v1 == 64'd0) ? ST_FIN : ST_MUL;
      ST_P_DIV0: state_next = ST_P_DIV;
      ST_P_DIV:  if (div_rsp.done) state_next = ST_P_Q1;
      ST_P_Q1:   state_next = ST_MUL;
      ST_P_Q2:   state_next = ST_MUL;
      ST_P_Q3:   state_next = ST_MUL;
      ST_P_Q4:   state_next = ST_P_SUM;
      ST_P_SUM:  state_next = ST_P_SUM2;
      ST_P_SUM2: state_next = ST_P_FIN;
      ST_P_FIN:  state_next = ST_FIN;
      ST_FIN:    if (load_out) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib       <= '0;
      press_calib_low  <= '0;
      press_calib_high <= '0;
      press_calib_nine <= '0;
    end else if (write_enable) begin
      case (reg_index)
        REG_TEMP_CALIB: temp_calib       <= write_data[47:0];
        REG_PRESS_LOW:  press_calib_low  <= write_data;
        REG_PRESS_HIGH: press_calib_high <= write_data;
        REG_PRESS_NINE: press_calib_nine <= write_data[15:0];
        default:        ;
      endcase
    end
  end

  // shared multiplier: product registered, then accumulated
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_phase <= '0;
    end else if (state == ST_MUL) begin
      mul_phase <= mul_phase + 2'd1;
    end else begin
      mul_phase <= '0;
    end
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (state == ST_MUL) begin
      case (mul_phase)
        2'd1:    mul_r <= prod;
        2'd2:    mul_r <= mul_r + {prod[31:0], 32'd0};
        2'd3:    mul_r <= mul_r + {prod[31:0], 32'd0};
        default: ;
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      fine_temperature <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            adc       <= in_ch.adc_value;
            res_temp  <= '0;
            res_press <= '0;
            res_zero  <= 1'b0;
          end
        end
        // temperature, 32-bit wrapping
        ST_T_X: begin
          mul_a <= sext32(tx); mul_b <= t2; ret <= ST_T_A;
        end
        ST_T_A: begin
          ta    <= 32'($signed(mul_r[31:0]) >>> 11);
          mul_a <= sext32(td); mul_b <= sext32(td); ret <= ST_T_S;
        end
        ST_T_S: begin
          mul_a <= sext32(ts); mul_b <= t3; ret <= ST_T_B;
        end
        ST_T_B:   fine_temperature <= tfine;
        ST_T_OUT: res_temp <= 32'($signed(tscaled) >>> 8);
        // pressure, 64-bit wrapping
        ST_P_V1: begin
          v1    <= sext32(fine_temperature) - FINE_OFFSET;
          mul_a <= sext32(fine_temperature) - FINE_OFFSET;
          mul_b <= sext32(fine_temperature) - FINE_OFFSET;
          ret   <= ST_P_SQ;
        end
        ST_P_SQ: begin
          sq <= mul_r; mul_a <= mul_r; mul_b <= p6; ret <= ST_P_V2A;
        end
        ST_P_V2A: begin
          v2 <= mul_r; mul_a <= v1; mul_b <= p5; ret <= ST_P_V2B;
        end
        ST_P_V2B: begin
          v2 <= v2 + {mul_r[46:0], 17'd0}; mul_a <= sq; mul_b <= p3; ret <= ST_P_N1;
        end
        ST_P_N1: begin
          v2    <= v2 + {p4[28:0], 35'd0};
          acc   <= 64'($signed(mul_r) >>> 8);
          mul_a <= v1; mul_b <= p2; ret <= ST_P_N2;
        end
        ST_P_N2: acc <= acc + {mul_r[51:0], 12'd0};
        ST_P_N3: begin
          mul_a <= PRESS_BIAS + acc; mul_b <= p1; ret <= ST_P_F1;
        end
        ST_P_F1: v1 <= 64'($signed(mul_r) >>> 33);
        ST_P_CHK: begin
          if (v1 == 64'd0) begin
            res_zero <= 1'b1;
          end
          // numerator before the scale multiply
          mul_a <= ((PRESS_BASE - {44'd0, adc}) << 31) - v2;
          mul_b <= PRESS_SCALE;
          ret   <= ST_P_DIV0;
        end
        ST_P_DIV: begin
          if (div_rsp.done) begin
            p <= div_rsp.quot;
          end
        end
        ST_P_Q1: begin
          acc   <= 64'($signed(p) >>> 13);
          mul_a <= p9; mul_b <= 64'($signed(p) >>> 13); ret <= ST_P_Q2;
        end
        ST_P_Q2: begin
          mul_a <= mul_r; mul_b <= acc; ret <= ST_P_Q3;
        end
        ST_P_Q3: begin
          v1 <= 64'($signed(mul_r) >>> 25); mul_a <= p8; mul_b <= p; ret <= ST_P_Q4;
        end
        ST_P_Q4:   v2  <= 64'($signed(mul_r) >>> 19);
        ST_P_SUM:  acc <= p + v1;
        ST_P_SUM2: acc <= acc + v2;
        ST_P_FIN: begin
          res_press <= 32'(64'($signed(acc) >>> 8) + {p7[59:0], 4'd0});
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.temperature_centi <= res_temp;
      out_ch.pressure_q24_8    <= res_press;
      out_ch.zero_divisor      <= res_zero;
    end
  end

  assign out_ch.valid = out_valid;
  assign in_ch.ready  = in_ready;

  tpc_sdiv64 u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule
